/* sv/m4a_pkg.sv */
// Shared types, opcodes and arithmetic helpers of the 4x4 fixed-point matrix unit.
// Depends on nothing; used by every module of the block.
`default_nettype none
package m4a_pkg;

   typedef logic signed [31:0] word_type;
   typedef word_type [3:0] row_type;
   typedef row_type [3:0] mat_type;

   typedef enum logic [2:0] {
      OP_LOAD_A = 3'd0,
      OP_LOAD_B = 3'd1,
      OP_ADD    = 3'd2,
      OP_SUB    = 3'd3,
      OP_SCALE  = 3'd4,
      OP_MUL    = 3'd5,
      OP_TRANS  = 3'd6,
      OP_DET    = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      LANE_MUL  = 2'd0,
      LANE_ADD  = 2'd1,
      LANE_SUB  = 2'd2,
      LANE_PASS = 2'd3
   } lane_op_type;

   typedef struct packed {
      logic [2:0] opcode;
      logic [1:0] row_index;
      word_type   elem_0;
      word_type   elem_1;
      word_type   elem_2;
      word_type   elem_3;
   } req_type;

   typedef struct packed {
      logic [1:0] out_row;
      word_type   res_0;
      word_type   res_1;
      word_type   res_2;
      word_type   res_3;
      logic       is_scalar;
      logic       last;
   } rsp_type;

   // Control handed from the sequencer to the merge stage
   typedef struct packed {
      logic       vld;
      op_type     op;
      logic [3:0] step;
   } mrg_ctl_type;

   // Operand source codes: 0..15 entries of A, then minors, then cofactors
   localparam logic [4:0] SRC_MNR_BASE = 5'd16;
   localparam logic [4:0] SRC_COF_BASE = 5'd22;
   localparam int         SRC_COUNT    = 32;

   // Determinant schedule: minors, cofactors, one idle step, total
   localparam logic [3:0] DSTEP_MNR_LAST  = 4'd2;
   localparam logic [3:0] DSTEP_COF_FIRST = 4'd3;
   localparam logic [3:0] DSTEP_COF_LAST  = 4'd6;
   localparam logic [3:0] DSTEP_TOTAL     = 4'd8;

   localparam logic [4:0] LAST_STEP_ROW = 5'd3;
   localparam logic [4:0] LAST_STEP_MUL = 5'd15;
   localparam logic [4:0] LAST_STEP_DET = 5'd8;

   function automatic word_type sat_add(input word_type a, input word_type b,
                                        input logic sub);
      logic signed [32:0] s;
      s = sub ? (33'(a) - 33'(b)) : (33'(a) + 33'(b));
      if (s[32] != s[31]) begin
         return s[32] ? word_type'(32'sh8000_0000) : word_type'(32'sh7FFF_FFFF);
      end
      return s[31:0];
   endfunction

   // Operand pair {x, y} of each lane at each determinant step
   function automatic logic [9:0] det_src(input logic [3:0] step, input logic [1:0] lane);
      logic [9:0] r;
      unique case ({step, lane})
         {4'd0, 2'd0}: r = {5'd10, 5'd15};
         {4'd0, 2'd1}: r = {5'd11, 5'd14};
         {4'd0, 2'd2}: r = {5'd9,  5'd15};
         {4'd0, 2'd3}: r = {5'd11, 5'd13};
         {4'd1, 2'd0}: r = {5'd9,  5'd14};
         {4'd1, 2'd1}: r = {5'd10, 5'd13};
         {4'd1, 2'd2}: r = {5'd8,  5'd15};
         {4'd1, 2'd3}: r = {5'd11, 5'd12};
         {4'd2, 2'd0}: r = {5'd8,  5'd14};
         {4'd2, 2'd1}: r = {5'd10, 5'd12};
         {4'd2, 2'd2}: r = {5'd8,  5'd13};
         {4'd2, 2'd3}: r = {5'd9,  5'd12};
         {4'd3, 2'd0}: r = {5'd5,  SRC_MNR_BASE + 5'd0};
         {4'd3, 2'd1}: r = {5'd6,  SRC_MNR_BASE + 5'd1};
         {4'd3, 2'd2}: r = {5'd7,  SRC_MNR_BASE + 5'd2};
         {4'd4, 2'd0}: r = {5'd4,  SRC_MNR_BASE + 5'd0};
         {4'd4, 2'd1}: r = {5'd6,  SRC_MNR_BASE + 5'd3};
         {4'd4, 2'd2}: r = {5'd7,  SRC_MNR_BASE + 5'd4};
         {4'd5, 2'd0}: r = {5'd4,  SRC_MNR_BASE + 5'd1};
         {4'd5, 2'd1}: r = {5'd5,  SRC_MNR_BASE + 5'd3};
         {4'd5, 2'd2}: r = {5'd7,  SRC_MNR_BASE + 5'd5};
         {4'd6, 2'd0}: r = {5'd4,  SRC_MNR_BASE + 5'd2};
         {4'd6, 2'd1}: r = {5'd5,  SRC_MNR_BASE + 5'd4};
         {4'd6, 2'd2}: r = {5'd6,  SRC_MNR_BASE + 5'd5};
         {4'd8, 2'd0}: r = {5'd0,  SRC_COF_BASE + 5'd0};
         {4'd8, 2'd1}: r = {5'd1,  SRC_COF_BASE + 5'd1};
         {4'd8, 2'd2}: r = {5'd2,  SRC_COF_BASE + 5'd2};
         {4'd8, 2'd3}: r = {5'd3,  SRC_COF_BASE + 5'd3};
         default:      r = 10'd0;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

/* sv/matrix4x4_alu.sv */
// 4x4 Q16.16 matrix unit: loads, add, subtract, scale, multiply, transpose, determinant.
// Loads write a row of A or B while idle. Add, subtract, scale and transpose work row by
// row; multiply forms one element per cycle over four lanes; determinant steps through
// minors, cofactors and the total. A write-back state follows, then rows go out one per
// accepted result (one scalar for the determinant), one request at a time. Reset clears A,
// B, state, step, row and merge-valid registers. Depends on m4a_pkg, m4a_lane and m4a_merge.
`default_nettype none
module matrix4x4_alu
   import m4a_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic      req_stall,
   input  req_type   req_data,
   output logic      rsp_valid,
   input  wire logic rsp_stall,
   output rsp_type   rsp_data
);

   // Sequencer states
   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_CALC  = 4'b0010,
      ST_WRITE = 4'b0100,
      ST_EMIT  = 4'b1000
   } state_type;

   state_type   state_ff, state_in;
   mat_type     a_ff, a_in;
   mat_type     b_ff, b_in;
   op_type      op_ff, op_in;
   word_type    scal_ff, scal_in;
   logic [4:0]  step_ff, step_in;
   logic [1:0]  emit_row_ff, emit_row_in;
   rsp_type     rsp_ff, rsp_in;
   mrg_ctl_type mrg_ctl_ff, mrg_ctl_in;

   logic [4:0]  last_step;
   logic        issue;
   logic [1:0]  next_row;
   lane_op_type lane_kind [4];
   word_type    lane_x [4];
   word_type    lane_y [4];
   word_type    lane_res [4];
   word_type    src_vec [SRC_COUNT];
   logic [9:0]  dsrc [4];
   mat_type     nm;
   word_type    mnr [6];
   word_type    cof [4];
   word_type    det;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_EMIT);
   assign rsp_data  = rsp_ff;
   assign next_row  = emit_row_ff + 2'd1;

   always_comb begin
      unique case (op_ff)
         OP_MUL:  last_step = LAST_STEP_MUL;
         OP_DET:  last_step = LAST_STEP_DET;
         default: last_step = LAST_STEP_ROW;
      endcase
   end

   assign issue = (state_ff == ST_CALC) && (step_ff <= last_step);

   // Operand sources for the determinant schedule
   always_comb begin
      for (int s = 0; s < SRC_COUNT; s++) begin
         src_vec[s] = '0;
      end
      for (int s = 0; s < 16; s++) begin
         src_vec[s] = a_ff[s / 4][s % 4];
      end
      for (int s = 0; s < 6; s++) begin
         src_vec[int'(SRC_MNR_BASE) + s] = mnr[s];
      end
      for (int s = 0; s < 4; s++) begin
         src_vec[int'(SRC_COF_BASE) + s] = cof[s];
      end
   end

   // Steer operands into each lane for the current step
   always_comb begin
      for (int l = 0; l < 4; l++) begin
         dsrc[l] = det_src(step_ff[3:0], 2'(l));
         unique case (op_ff)
            OP_ADD: begin
               lane_kind[l] = LANE_ADD;
               lane_x[l]    = a_ff[step_ff[1:0]][l];
               lane_y[l]    = b_ff[step_ff[1:0]][l];
            end
            OP_SUB: begin
               lane_kind[l] = LANE_SUB;
               lane_x[l]    = a_ff[step_ff[1:0]][l];
               lane_y[l]    = b_ff[step_ff[1:0]][l];
            end
            OP_SCALE: begin
               lane_kind[l] = LANE_MUL;
               lane_x[l]    = a_ff[step_ff[1:0]][l];
               lane_y[l]    = scal_ff;
            end
            OP_MUL: begin
               // lane l forms A[i][l] * B[l][j]
               lane_kind[l] = LANE_MUL;
               lane_x[l]    = a_ff[step_ff[3:2]][l];
               lane_y[l]    = b_ff[l][step_ff[1:0]];
            end
            OP_DET: begin
               lane_kind[l] = LANE_MUL;
               lane_x[l]    = src_vec[dsrc[l][9:5]];
               lane_y[l]    = src_vec[dsrc[l][4:0]];
            end
            default: begin
               // transpose: row i of the result is column i of A
               lane_kind[l] = LANE_PASS;
               lane_x[l]    = a_ff[l][step_ff[1:0]];
               lane_y[l]    = '0;
            end
         endcase
      end
   end

   for (genvar g = 0; g < 4; g++) begin : g_lane
      m4a_lane #(
         .FRAC_BITS (FRAC_BITS)
      ) u_lane (
         .clock (clock),
         .kind  (lane_kind[g]),
         .x     (lane_x[g]),
         .y     (lane_y[g]),
         .res   (lane_res[g])
      );
   end

   m4a_merge u_merge (
      .clock (clock),
      .ctl   (mrg_ctl_ff),
      .p     (lane_res),
      .nm    (nm),
      .mnr   (mnr),
      .cof   (cof),
      .det   (det)
   );

   always_comb begin
      state_in    = state_ff;
      a_in        = a_ff;
      b_in        = b_ff;
      op_in       = op_ff;
      scal_in     = scal_ff;
      step_in     = step_ff;
      emit_row_in = emit_row_ff;
      rsp_in      = rsp_ff;

      // results of a lane step reach the merge stage in the following cycle, with the registered control
      mrg_ctl_in.vld  = issue;
      mrg_ctl_in.op   = op_ff;
      mrg_ctl_in.step = step_ff[3:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (op_type'(req_data.opcode) == OP_LOAD_A) begin
                  a_in[req_data.row_index] = {req_data.elem_3, req_data.elem_2,
                                              req_data.elem_1, req_data.elem_0};
               end else if (op_type'(req_data.opcode) == OP_LOAD_B) begin
                  b_in[req_data.row_index] = {req_data.elem_3, req_data.elem_2,
                                              req_data.elem_1, req_data.elem_0};
               end else begin
                  op_in    = op_type'(req_data.opcode);
                  scal_in  = req_data.elem_0;
                  step_in  = '0;
                  state_in = ST_CALC;
               end
            end
         end
         ST_CALC: begin
            if (issue) begin
               step_in = step_ff + 5'd1;
            end
            // advance once the last step has been merged
            if (mrg_ctl_ff.vld && (mrg_ctl_ff.step == last_step[3:0])) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            emit_row_in = '0;
            state_in    = ST_EMIT;
            if (op_ff == OP_DET) begin
               rsp_in = '{out_row: 2'd0, res_0: det, res_1: '0, res_2: '0, res_3: '0,
                          is_scalar: 1'b1, last: 1'b1};
            end else begin
               a_in   = nm;
               rsp_in = '{out_row: 2'd0, res_0: nm[0][0], res_1: nm[0][1],
                          res_2: nm[0][2], res_3: nm[0][3], is_scalar: 1'b0, last: 1'b0};
            end
         end
         ST_EMIT: begin
            if (!rsp_stall) begin
               if (rsp_ff.last) begin
                  state_in = ST_IDLE;
               end else begin
                  emit_row_in = next_row;
                  rsp_in = '{out_row: next_row, res_0: a_ff[next_row][0],
                             res_1: a_ff[next_row][1], res_2: a_ff[next_row][2],
                             res_3: a_ff[next_row][3], is_scalar: 1'b0,
                             last: (next_row == 2'd3)};
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         a_ff           <= '0;
         b_ff           <= '0;
         step_ff        <= '0;
         emit_row_ff    <= '0;
         mrg_ctl_ff.vld <= 1'b0;
      end else begin
         state_ff       <= state_in;
         a_ff           <= a_in;
         b_ff           <= b_in;
         step_ff        <= step_in;
         emit_row_ff    <= emit_row_in;
         mrg_ctl_ff.vld <= mrg_ctl_in.vld;
      end
   end

   always_ff @(posedge clock) begin
      op_ff           <= op_in;
      scal_ff         <= scal_in;
      rsp_ff          <= rsp_in;
      mrg_ctl_ff.op   <= mrg_ctl_in.op;
      mrg_ctl_ff.step <= mrg_ctl_in.step;
   end

endmodule
`default_nettype wire

/* sv/m4a_lane.sv */
// One arithmetic lane: saturating fixed-point multiply, add, subtract or pass.
// Depends on m4a_pkg.
`default_nettype none
module m4a_lane
   import m4a_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  wire logic        clock,
   input  lane_op_type      kind,
   input  word_type         x,
   input  word_type         y,
   output word_type         res
);

   localparam logic signed [63:0] MAX_V = 64'sd2147483647;
   localparam logic signed [63:0] MIN_V = -64'sd2147483648;

   logic signed [63:0] prod;
   logic signed [63:0] shr;
   word_type           mul_sat;
   word_type           res_in;
   word_type           res_ff;

   always_comb begin
      prod = 64'(x) * 64'(y);
      shr  = prod >>> FRAC_BITS;
      if (shr > MAX_V) begin
         mul_sat = word_type'(32'sh7FFF_FFFF);
      end else if (shr < MIN_V) begin
         mul_sat = word_type'(32'sh8000_0000);
      end else begin
         mul_sat = shr[31:0];
      end
      unique case (kind)
         LANE_MUL:  res_in = mul_sat;
         LANE_ADD:  res_in = sat_add(x, y, 1'b0);
         LANE_SUB:  res_in = sat_add(x, y, 1'b1);
         LANE_PASS: res_in = x;
         default:   res_in = x;
      endcase
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   assign res = res_ff;

endmodule
`default_nettype wire

/* sv/m4a_merge.sv */
// Merge stage: combines the four lane results into matrix rows, elements,
// minors, cofactors and the determinant. Depends on m4a_pkg.
`default_nettype none
module m4a_merge
   import m4a_pkg::*;
(
   input  wire logic  clock,
   input  mrg_ctl_type ctl,
   input  word_type   p [4],
   output mat_type    nm,
   output word_type   mnr [6],
   output word_type   cof [4],
   output word_type   det
);

   mat_type  nm_ff;
   word_type mnr_ff [6];
   word_type cof_ff [4];
   word_type det_ff;
   word_type tree_lo;
   word_type tree_hi;
   word_type tree;
   word_type diff_lo;
   word_type diff_hi;
   word_type cof3;
   word_type total;

   always_comb begin
      tree_lo = sat_add(p[0], p[1], 1'b0);
      tree_hi = sat_add(p[2], p[3], 1'b0);
      tree    = sat_add(tree_lo, tree_hi, 1'b0);
      diff_lo = sat_add(p[0], p[1], 1'b1);
      diff_hi = sat_add(p[2], p[3], 1'b1);
      cof3    = sat_add(diff_lo, p[2], 1'b0);
      total   = sat_add(cof3, p[3], 1'b1);
   end

   always_ff @(posedge clock) begin
      if (ctl.vld) begin
         unique case (ctl.op)
            OP_MUL: begin
               nm_ff[ctl.step[3:2]][ctl.step[1:0]] <= tree;
            end
            OP_DET: begin
               if (ctl.step <= DSTEP_MNR_LAST) begin
                  mnr_ff[3'({ctl.step[1:0], 1'b0})] <= diff_lo;
                  mnr_ff[3'({ctl.step[1:0], 1'b1})] <= diff_hi;
               end else if (ctl.step <= DSTEP_COF_LAST) begin
                  cof_ff[2'(ctl.step - DSTEP_COF_FIRST)] <= cof3;
               end else if (ctl.step == DSTEP_TOTAL) begin
                  det_ff <= total;
               end
            end
            default: begin
               nm_ff[ctl.step[1:0]] <= {p[3], p[2], p[1], p[0]};
            end
         endcase
      end
   end

   assign nm  = nm_ff;
   assign mnr = mnr_ff;
   assign cof = cof_ff;
   assign det = det_ff;

endmodule
`default_nettype wire

/* tb/tb_matrix4x4_alu.sv */
// Self-checking bench for the 4x4 Q16.16 matrix unit: random and directed requests,
// an own model of A and B that predicts every emitted row and determinant.
// Depends on m4a_pkg and matrix4x4_alu.
`default_nettype none

class matrix_scoreboard;
   m4a_pkg::word_type mat_a [16];
   m4a_pkg::word_type mat_b [16];
   m4a_pkg::rsp_type  rows_due [$];
   int                errors;

   function new();
      foreach (mat_a[i]) begin
         mat_a[i] = 0;
         mat_b[i] = 0;
      end
      errors = 0;
   endfunction

   function m4a_pkg::word_type clip(logic signed [65:0] v);
      if (v > 66'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
      if (v < -66'sh8000_0000) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   // floor shift of the exact product, then clip
   function m4a_pkg::word_type qmul(m4a_pkg::word_type a, m4a_pkg::word_type b);
      logic signed [65:0] p;
      p = 66'(a) * 66'(b);
      return clip(p >>> 16);
   endfunction

   function m4a_pkg::word_type qadd(m4a_pkg::word_type a, m4a_pkg::word_type b);
      return clip(66'(a) + 66'(b));
   endfunction

   function m4a_pkg::word_type qsub(m4a_pkg::word_type a, m4a_pkg::word_type b);
      return clip(66'(a) - 66'(b));
   endfunction

   function m4a_pkg::word_type minor2(int c0, int c1);
      return qsub(qmul(mat_a[8+c0], mat_a[12+c1]), qmul(mat_a[8+c1], mat_a[12+c0]));
   endfunction

   function m4a_pkg::word_type cofactor3(int c0, int c1, int c2);
      m4a_pkg::word_type t;
      t = qsub(qmul(mat_a[4+c0], minor2(c1, c2)), qmul(mat_a[4+c1], minor2(c0, c2)));
      return qadd(t, qmul(mat_a[4+c2], minor2(c0, c1)));
   endfunction

   function m4a_pkg::word_type det_of_a();
      m4a_pkg::word_type t0, t1, t2, t3;
      t0 = qmul(mat_a[0], cofactor3(1, 2, 3));
      t1 = qmul(mat_a[1], cofactor3(0, 2, 3));
      t2 = qmul(mat_a[2], cofactor3(0, 1, 3));
      t3 = qmul(mat_a[3], cofactor3(0, 1, 2));
      return qsub(qadd(qsub(t0, t1), t2), t3);
   endfunction

   // Update A/B and queue the rows this request must produce
   function void note_request(m4a_pkg::req_type r);
      m4a_pkg::word_type e [4];
      m4a_pkg::word_type nm [16];
      m4a_pkg::rsp_type  o;
      m4a_pkg::op_type   op;
      int k;
      e[0] = r.elem_0; e[1] = r.elem_1; e[2] = r.elem_2; e[3] = r.elem_3;
      op = m4a_pkg::op_type'(r.opcode);
      o = '0;
      case (op)
         m4a_pkg::OP_LOAD_A: begin
            for (int j = 0; j < 4; j++) mat_a[r.row_index*4+j] = e[j];
            return;
         end
         m4a_pkg::OP_LOAD_B: begin
            for (int j = 0; j < 4; j++) mat_b[r.row_index*4+j] = e[j];
            return;
         end
         m4a_pkg::OP_DET: begin
            o.res_0 = det_of_a();
            o.is_scalar = 1'b1;
            o.last = 1'b1;
            rows_due.push_back(o);
            return;
         end
         default: ;
      endcase
      for (int i = 0; i < 4; i++)
         for (int j = 0; j < 4; j++) begin
            k = i*4 + j;
            case (op)
               m4a_pkg::OP_ADD:   nm[k] = qadd(mat_a[k], mat_b[k]);
               m4a_pkg::OP_SUB:   nm[k] = qsub(mat_a[k], mat_b[k]);
               m4a_pkg::OP_SCALE: nm[k] = qmul(mat_a[k], e[0]);
               m4a_pkg::OP_MUL:
                  nm[k] = qadd(qadd(qmul(mat_a[i*4], mat_b[j]), qmul(mat_a[i*4+1], mat_b[4+j])),
                               qadd(qmul(mat_a[i*4+2], mat_b[8+j]),
                                    qmul(mat_a[i*4+3], mat_b[12+j])));
               default:           nm[k] = mat_a[j*4+i];
            endcase
         end
      mat_a = nm;
      for (int i = 0; i < 4; i++) begin
         o = '0;
         o.out_row = i[1:0];
         o.res_0 = mat_a[i*4]; o.res_1 = mat_a[i*4+1];
         o.res_2 = mat_a[i*4+2]; o.res_3 = mat_a[i*4+3];
         o.last = (i == 3);
         rows_due.push_back(o);
      end
   endfunction

   function void check_row(m4a_pkg::rsp_type got);
      m4a_pkg::rsp_type want;
      if (rows_due.size() == 0) begin
         $display("%0t: unexpected result, expected none, actual %h", $time, got);
         errors++;
         return;
      end
      want = rows_due.pop_front();
      if (got.out_row != want.out_row || got.res_0 != want.res_0 ||
          got.res_1 != want.res_1 || got.res_2 != want.res_2 ||
          got.res_3 != want.res_3 || got.is_scalar != want.is_scalar ||
          got.last != want.last) begin
         $display("%0t: mismatch, expected %h, actual %h", $time, want, got);
         errors++;
      end
   endfunction
endclass

module tb_matrix4x4_alu;
   import m4a_pkg::*;

   localparam int STALL_LIMIT = 20000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   matrix_scoreboard board;
   int  quiet_cycles;
   bit  hold_off_now;

   matrix4x4_alu dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Random Q16.16 word, biased toward extremes and small values
   function automatic word_type pick_word();
      case ($urandom_range(0, 7))
         0: return 32'sh7FFF_FFFF;
         1: return 32'sh8000_0000;
         2: return 32'($signed($urandom_range(0, 8'hFF) - 128)) <<< 12;
         3, 4: return 32'($signed($urandom_range(0, 20'hFFFFF) - 20'h80000));
         default: return $urandom();
      endcase
   endfunction

   // Send one request: drop valid for a random gap when gaps is set, then hold it until accepted;
   // valid stays high after acceptance only when the next request follows at once
   task automatic send_request(input op_type op, input logic [1:0] row,
                               input word_type e0, input word_type e1,
                               input word_type e2, input word_type e3, input bit gaps);
      int gap;
      gap = gaps ? $urandom_range(0, 18) : 0;
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{opcode: op, row_index: row, elem_0: e0, elem_1: e1,
                     elem_2: e2, elem_3: e3};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_request(req_data);
   endtask

   task automatic load_random(input op_type op, input logic [1:0] row);
      send_request(op, row, pick_word(), pick_word(), pick_word(), pick_word(), 1'b1);
   endtask

   // Receiver: random stall per result; one long hold-off midway
   initial begin
      int gap;
      rsp_stall = 1'b1;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_off_now) begin
            rsp_stall <= 1'b1;
            repeat (300) @(posedge clock);
            hold_off_now = 1'b0;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         board.check_row(rsp_data);
         rsp_stall <= 1'b1;
      end
   end

   // Watchdog: count cycles with no handshake on either side
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("[matrix4x4_alu] ERROR");
         $finish;
      end
   end

   initial begin
      op_type op;
      board = new();
      hold_off_now = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset state, extremes, every opcode, saturation, transpose
      send_request(OP_DET, 2'd3, '1, '1, '1, '1, 1'b0);
      send_request(OP_ADD, 2'd0, 0, 0, 0, 0, 1'b0);
      for (int r = 0; r < 4; r++)
         send_request(OP_LOAD_A, r[1:0], 32'sh7FFF_FFFF, 32'sh8000_0000,
                      32'sh0001_0000, 32'shFFFF_0000, 1'b0);
      for (int r = 0; r < 4; r++)
         send_request(OP_LOAD_B, r[1:0], 32'sh7FFF_FFFF, 32'sh8000_0000,
                      32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0);
      send_request(OP_ADD, 2'd1, '1, '1, '1, '1, 1'b0);
      send_request(OP_SUB, 2'd2, 0, 0, 0, 0, 1'b0);
      send_request(OP_SCALE, 2'd3, 32'sh8000_0000, '1, '1, '1, 1'b0);
      send_request(OP_MUL, 2'd0, 0, 0, 0, 0, 1'b0);
      send_request(OP_TRANS, 2'd0, 0, 0, 0, 0, 1'b0);
      send_request(OP_DET, 2'd0, 0, 0, 0, 0, 1'b0);
      send_request(OP_LOAD_A, 2'd0, 32'sh0002_0000, 32'sh0000_8000, 0, 32'shFFFF_FFFF, 1'b0);
      send_request(OP_LOAD_A, 2'd1, 0, 32'sh0003_0000, 32'sh0001_0000, 0, 1'b0);
      send_request(OP_LOAD_A, 2'd2, 32'sh0001_0000, 0, 32'sh0004_0000, 32'sh0000_0001, 1'b0);
      send_request(OP_LOAD_A, 2'd3, 0, 32'shFFFE_0000, 0, 32'sh0005_0000, 1'b0);
      send_request(OP_DET, 2'd1, 0, 0, 0, 0, 1'b0);
      send_request(OP_SCALE, 2'd0, 32'sh0000_0001, 0, 0, 0, 1'b0);

      // Random: mostly fresh matrices followed by an operation on them
      for (int n = 0; n < 40; n++) begin
         if (n == 16) hold_off_now = 1'b1;
         case ($urandom_range(0, 5))
            0: load_random(OP_LOAD_A, 2'($urandom_range(0, 3)));
            1: load_random(OP_LOAD_B, 2'($urandom_range(0, 3)));
            2: for (int r = 0; r < 4; r++) load_random(OP_LOAD_A, r[1:0]);
            3: for (int r = 0; r < 4; r++) load_random(OP_LOAD_B, r[1:0]);
            default: begin
               op = op_type'($urandom_range(2, 7));
               send_request(op, 2'($urandom()), pick_word(), $urandom(), $urandom(),
                            $urandom(), 1'b1);
            end
         endcase
      end
      send_request(OP_DET, 2'd0, 0, 0, 0, 0, 1'b1);
      req_valid <= 1'b0;

      // Drain: wait for every queued row, then let the unit settle before reporting
      while (board.rows_due.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (board.errors == 0)
         $display("[matrix4x4_alu] OK");
      else
         $display("[matrix4x4_alu] ERROR");
      $finish;
   end
endmodule
`default_nettype wire
